// ----- hw/rtl/spp_pkg.sv -----
package spp_pkg;

	// Frame status codes reported with each result item.
	typedef enum logic [1:0] {
		STATUS_OK             = 2'd0,
		STATUS_BAD_LENGTH     = 2'd1,
		STATUS_BAD_WINDOW     = 2'd2,
		STATUS_BAD_FRAME_SIZE = 2'd3
	} status_t;

	// Setting identifiers that the block stores.
	localparam logic [15:0] ID_TABLE_SIZE  = 16'd1;
	localparam logic [15:0] ID_PUSH        = 16'd2;
	localparam logic [15:0] ID_STREAMS     = 16'd3;
	localparam logic [15:0] ID_WINDOW      = 16'd4;
	localparam logic [15:0] ID_FRAME_SIZE  = 16'd5;
	localparam logic [15:0] ID_HEADER_LIST = 16'd6;

	// Entry layout: 16-bit identifier and 32-bit value.
	localparam int unsigned ENTRY_BYTES = 6;
	localparam logic [2:0]  LAST_BYTE_POS = 3'(ENTRY_BYTES - 1);

	// Defaults after reset.
	localparam logic [31:0] RST_TABLE_SIZE      = 32'd4096;
	localparam logic [31:0] RST_PUSH            = 32'd1;
	localparam logic [31:0] RST_MAX_STREAMS     = 32'hffff_ffff;
	localparam logic [30:0] RST_INITIAL_WINDOW  = 31'd65535;
	localparam logic [23:0] RST_FRAME_SIZE      = 24'd16384;
	localparam logic [31:0] RST_MAX_HEADER_LIST = 32'hffff_ffff;

	// Lower end of the legal range of the maximum frame size.
	localparam logic [23:0] MIN_FRAME_SIZE = 24'd16384;

	// One payload byte after the input register.
	typedef struct packed {
		logic [7:0]  data_byte;
		logic [23:0] payload_length;
		logic        is_last;
		logic        length_bad;
	} item_t;

endpackage

// ----- hw/rtl/spp_ifs.sv -----
// Channel that carries one payload byte of a settings frame.
interface spp_byte_if;
	logic        valid;
	logic        ready;
	logic [7:0]  data_byte;
	logic [23:0] payload_length;
	logic        is_last;

	modport source (output valid, data_byte, payload_length, is_last, input ready);
	modport sink (input valid, data_byte, payload_length, is_last, output ready);
endinterface

// Channel that carries the status and settings after a frame.
interface spp_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [31:0] hdr_table_size;
	logic [31:0] push_enabled;
	logic [31:0] stream_limit;
	logic [30:0] init_window;
	logic [23:0] frame_limit;
	logic [31:0] hdr_list_limit;

	modport source (
		output valid, status, hdr_table_size, push_enabled, stream_limit,
			init_window, frame_limit, hdr_list_limit,
		input ready
	);
	modport sink (
		input valid, status, hdr_table_size, push_enabled, stream_limit,
			init_window, frame_limit, hdr_list_limit,
		output ready
	);
endinterface

// ----- hw/rtl/settings_payload_parser_unit.sv -----
// Path: a last byte is held in the input register, then its result in the result
// register until the result is taken.
// Throughput: one payload byte per cycle; the input register drains even while a
// result waits, and only a last byte stalls behind an untaken result.
// Reset: arst_n clears the frame state and loads the default peer settings;
// no clearing pass follows, so bytes are accepted as soon as reset is released.
module settings_payload_parser_unit (
	input  logic         clk,
	input  logic         arst_n,
	spp_byte_if.sink     payload,
	spp_result_if.source report
);
	import spp_pkg::*;

	logic  item_valid;
	item_t item;
	logic  advance;

	// Input register with the length check.
	spp_in_stage u_in_stage (
		.clk        (clk),
		.arst_n     (arst_n),
		.payload    (payload),
		.advance    (advance),
		.item_valid (item_valid),
		.item       (item)
	);

	// Entry assembly, settings and result register.
	spp_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item       (item),
		.advance    (advance),
		.report     (report)
	);

endmodule

// ----- hw/rtl/spp_in_stage.sv -----
module spp_in_stage (
	input  logic         clk,
	input  logic         arst_n,
	spp_byte_if.sink     payload,
	input  logic         advance,
	output logic         item_valid,
	output spp_pkg::item_t item
);
	import spp_pkg::*;

	logic       valid_s1;
	item_t      item_s1;
	logic       load;
	logic [9:0] byte_sum;
	logic [3:0] pair_sum;
	logic [2:0] mod_sum;
	logic       length_bad;

	// A new item may enter when the register is empty or drains this cycle.
	assign payload.ready = !valid_s1 || advance;
	assign load = payload.valid && payload.ready;

	// Length modulo six: odd, or not a multiple of three. Since 256 and 4 are
	// both one modulo three, the digit sums keep the residue.
	always_comb begin
		byte_sum = {2'b00, payload.payload_length[23:16]}
			+ {2'b00, payload.payload_length[15:8]}
			+ {2'b00, payload.payload_length[7:0]};
		pair_sum = {2'b00, byte_sum[9:8]} + {2'b00, byte_sum[7:6]}
			+ {2'b00, byte_sum[5:4]} + {2'b00, byte_sum[3:2]}
			+ {2'b00, byte_sum[1:0]};
		mod_sum = {1'b0, pair_sum[3:2]} + {1'b0, pair_sum[1:0]};
		length_bad = payload.payload_length[0]
			|| !((mod_sum == 3'd0) || (mod_sum == 3'd3) || (mod_sum == 3'd6));
	end

	// Occupancy of the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Item payload, captured on acceptance.
	always_ff @(posedge clk) begin
		if (load) begin
			item_s1.data_byte      <= payload.data_byte;
			item_s1.payload_length <= payload.payload_length;
			item_s1.is_last        <= payload.is_last;
			item_s1.length_bad     <= length_bad;
		end
	end

	assign item_valid = valid_s1;
	assign item       = item_s1;

endmodule

// ----- hw/rtl/spp_core.sv -----
module spp_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	input  spp_pkg::item_t item,
	output logic           advance,
	spp_result_if.source   report
);
	import spp_pkg::*;

	// Frame assembly state.
	logic        frame_active_q;
	logic [2:0]  entry_count_q;
	logic [39:0] entry_shift_q;
	status_t     frame_status_q;

	// Peer settings.
	logic [31:0] peer_table_size_q;
	logic [31:0] peer_push_q;
	logic [31:0] peer_streams_q;
	logic [30:0] peer_window_q;
	logic [23:0] peer_frame_size_q;
	logic [31:0] peer_header_list_q;

	// Result register.
	logic        res_valid_q;
	status_t     res_status_q;
	logic [31:0] res_table_size_q;
	logic [31:0] res_push_q;
	logic [31:0] res_streams_q;
	logic [30:0] res_window_q;
	logic [23:0] res_frame_size_q;
	logic [31:0] res_header_list_q;

	// Next-state values.
	logic [2:0]  count_d;
	logic [39:0] shift_d;
	status_t     status_d;
	logic [31:0] table_size_d;
	logic [31:0] push_d;
	logic [31:0] streams_d;
	logic [30:0] window_d;
	logic [23:0] frame_size_d;
	logic [31:0] header_list_d;
	logic        emit;

	// The item moves on unless it carries a result that cannot be stored yet.
	assign advance = item_valid && (!item.is_last || !res_valid_q || report.ready);
	assign emit    = advance && item.is_last;

	// Byte assembly and entry decode for the item in the input register.
	always_comb begin
		logic [15:0] id;
		logic [31:0] value;

		count_d       = frame_active_q ? entry_count_q : 3'd0;
		shift_d       = frame_active_q ? entry_shift_q : 40'd0;
		status_d      = frame_active_q ? frame_status_q
			: (item.length_bad ? STATUS_BAD_LENGTH : STATUS_OK);
		table_size_d  = peer_table_size_q;
		push_d        = peer_push_q;
		streams_d     = peer_streams_q;
		window_d      = peer_window_q;
		frame_size_d  = peer_frame_size_q;
		header_list_d = peer_header_list_q;
		id            = shift_d[39:24];
		value         = {shift_d[23:0], item.data_byte};

		if ((status_d == STATUS_OK) && (item.payload_length != 24'd0)) begin
			if (count_d >= LAST_BYTE_POS) begin
				count_d = 3'd0;
				shift_d = 40'd0;
				case (id)
					ID_TABLE_SIZE: table_size_d = value;
					ID_PUSH: push_d = value;
					ID_STREAMS: streams_d = value;
					ID_WINDOW: begin
						if (value[31]) begin
							status_d = STATUS_BAD_WINDOW;
						end else begin
							window_d = value[30:0];
						end
					end
					ID_FRAME_SIZE: begin
						if ((value[31:24] != 8'd0) || (value[23:0] < MIN_FRAME_SIZE)) begin
							status_d = STATUS_BAD_FRAME_SIZE;
						end else begin
							frame_size_d = value[23:0];
						end
					end
					ID_HEADER_LIST: header_list_d = value;
					default: ;
				endcase
			end else begin
				shift_d = {shift_d[31:0], item.data_byte};
				count_d = count_d + 3'd1;
			end
		end
	end

	// Frame and peer state; a last item closes the frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_active_q     <= 1'b0;
			entry_count_q      <= 3'd0;
			entry_shift_q      <= 40'd0;
			frame_status_q     <= STATUS_OK;
			peer_table_size_q  <= RST_TABLE_SIZE;
			peer_push_q        <= RST_PUSH;
			peer_streams_q     <= RST_MAX_STREAMS;
			peer_window_q      <= RST_INITIAL_WINDOW;
			peer_frame_size_q  <= RST_FRAME_SIZE;
			peer_header_list_q <= RST_MAX_HEADER_LIST;
		end else if (advance) begin
			peer_table_size_q  <= table_size_d;
			peer_push_q        <= push_d;
			peer_streams_q     <= streams_d;
			peer_window_q      <= window_d;
			peer_frame_size_q  <= frame_size_d;
			peer_header_list_q <= header_list_d;
			if (item.is_last) begin
				frame_active_q <= 1'b0;
				entry_count_q  <= 3'd0;
				entry_shift_q  <= 40'd0;
				frame_status_q <= STATUS_OK;
			end else begin
				frame_active_q <= 1'b1;
				entry_count_q  <= count_d;
				entry_shift_q  <= shift_d;
				frame_status_q <= status_d;
			end
		end
	end

	// Result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (emit) begin
			res_valid_q <= 1'b1;
		end else if (report.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// Result payload, loaded with the settings as left by the last item.
	always_ff @(posedge clk) begin
		if (emit) begin
			res_status_q      <= status_d;
			res_table_size_q  <= table_size_d;
			res_push_q        <= push_d;
			res_streams_q     <= streams_d;
			res_window_q      <= window_d;
			res_frame_size_q  <= frame_size_d;
			res_header_list_q <= header_list_d;
		end
	end

	assign report.valid          = res_valid_q;
	assign report.status         = res_status_q;
	assign report.hdr_table_size = res_table_size_q;
	assign report.push_enabled   = res_push_q;
	assign report.stream_limit   = res_streams_q;
	assign report.init_window    = res_window_q;
	assign report.frame_limit    = res_frame_size_q;
	assign report.hdr_list_limit = res_header_list_q;

	// A last item always leaves a result behind it.
	a_emit_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> res_valid_q)
		else $error("result not registered after last item");

	// Any other item keeps the frame open.
	a_mid_item_opens_frame: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !item.is_last |=> frame_active_q)
		else $error("frame not open after a middle item");

	// Between frames no status or partial entry lingers.
	a_idle_frame_clean: assert property (@(posedge clk) disable iff (!arst_n)
		!frame_active_q |-> (frame_status_q == STATUS_OK) && (entry_count_q == 3'd0))
		else $error("stale frame state between frames");

	// A pending result is never overwritten by a new last item.
	a_no_result_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !report.ready |-> !emit)
		else $error("pending result overwritten");

	// The stored frame size stays within its legal range.
	a_frame_size_range: assert property (@(posedge clk) disable iff (!arst_n)
		peer_frame_size_q >= MIN_FRAME_SIZE)
		else $error("stored frame size below minimum");

endmodule

// ----- test/settings_report_checker.sv -----
// Watches both channels of the settings payload parser, keeps its own copy of
// the peer settings and the entry assembly, and compares every report item
// with the oldest one it expects.
module settings_report_checker (
	input  logic  clk,
	input  logic  arst_n,
	spp_byte_if   payload,
	spp_result_if report,
	output int    failures,
	output int    outstanding,
	output int    reports_checked,
	output int    error_reports
);
	import spp_pkg::*;

	localparam logic [31:0] WINDOW_LIMIT     = 32'h7fff_ffff;
	localparam logic [31:0] FRAME_SIZE_LIMIT = 32'd16777215;

	// Frame status and the six peer settings, as one report item carries them.
	typedef struct packed {
		status_t     status;
		logic [31:0] table_size;
		logic [31:0] push;
		logic [31:0] streams;
		logic [30:0] window;
		logic [23:0] frame_size;
		logic [31:0] header_list;
	} peer_report_t;

	peer_report_t peer;
	peer_report_t expected_reports[$];
	logic [2:0]   entry_count;
	logic [39:0]  entry_bits;
	logic         in_frame;
	int           fail_total;
	int           checked_total;
	int           error_total;

	// Drop the partial entry and the frame status.
	task automatic clear_frame();
		entry_count = '0;
		entry_bits  = '0;
		in_frame    = 1'b0;
		peer.status = STATUS_OK;
	endtask

	// One complete entry updates the matching setting; bad values flag the frame.
	task automatic store_setting(input logic [15:0] id, input logic [31:0] val);
		case (id)
			ID_TABLE_SIZE: peer.table_size = val;
			ID_PUSH: peer.push = val;
			ID_STREAMS: peer.streams = val;
			ID_WINDOW: begin
				if (val > WINDOW_LIMIT)
					peer.status = STATUS_BAD_WINDOW;
				else
					peer.window = val[30:0];
			end
			ID_FRAME_SIZE: begin
				if (val < 32'(MIN_FRAME_SIZE) || val > FRAME_SIZE_LIMIT)
					peer.status = STATUS_BAD_FRAME_SIZE;
				else
					peer.frame_size = val[23:0];
			end
			ID_HEADER_LIST: peer.header_list = val;
			default: ;
		endcase
	endtask

	// Advance the parser by one accepted payload item.
	task automatic take_payload_byte(input logic [7:0] data, input logic [23:0] len,
			input logic last);
		if (!in_frame) begin
			in_frame    = 1'b1;
			entry_count = '0;
			entry_bits  = '0;
			peer.status = (len % ENTRY_BYTES != 0) ? STATUS_BAD_LENGTH : STATUS_OK;
		end
		if (peer.status == STATUS_OK && len != 0) begin
			if (entry_count >= LAST_BYTE_POS) begin
				entry_count = '0;
				store_setting(entry_bits[39:24], {entry_bits[23:0], data});
				entry_bits = '0;
			end else begin
				entry_bits  = {entry_bits[31:0], data};
				entry_count = entry_count + 3'd1;
			end
		end
		if (last) begin
			expected_reports.push_back(peer);
			clear_frame();
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
			fail_total++;
		end
	endtask

	// Compare results first: a report never comes from a byte taken at the same edge.
	always @(posedge clk or negedge arst_n) begin
		peer_report_t want;
		if (!arst_n) begin
			expected_reports.delete();
			clear_frame();
			peer.table_size  = RST_TABLE_SIZE;
			peer.push        = RST_PUSH;
			peer.streams     = RST_MAX_STREAMS;
			peer.window      = RST_INITIAL_WINDOW;
			peer.frame_size  = RST_FRAME_SIZE;
			peer.header_list = RST_MAX_HEADER_LIST;
		end else begin
			if (report.valid && report.ready) begin
				if (expected_reports.size() == 0) begin
					$error("settings report item with no frame pending");
					fail_total++;
				end else begin
					want = expected_reports.pop_front();
					checked_total++;
					if (want.status != STATUS_OK)
						error_total++;
					check_field("status", 32'(want.status), 32'(report.status));
					check_field("hdr_table_size", want.table_size,
						report.hdr_table_size);
					check_field("push_enabled", want.push, report.push_enabled);
					check_field("stream_limit", want.streams,
						report.stream_limit);
					check_field("init_window", 32'(want.window),
						32'(report.init_window));
					check_field("frame_limit", 32'(want.frame_size),
						32'(report.frame_limit));
					check_field("hdr_list_limit", want.header_list,
						report.hdr_list_limit);
				end
			end
			if (payload.valid && payload.ready)
				take_payload_byte(payload.data_byte, payload.payload_length,
					payload.is_last);
		end
		failures        <= fail_total;
		outstanding     <= expected_reports.size();
		reports_checked <= checked_total;
		error_reports   <= error_total;
	end

endmodule

// ----- test/tb_settings_payload_parser_unit.sv -----
// Feeds settings frames into the parser: a few hand-picked frames, then random
// frames under three throttling patterns, while the checker compares the reports.
module tb_settings_payload_parser_unit;
	import spp_pkg::*;

	logic clk;
	logic arst_n;

	spp_byte_if   byte_ch ();
	spp_result_if result_ch ();

	int failures;
	int outstanding;
	int reports_checked;
	int error_reports;

	int items_sent;
	int send_idle_pct;
	int recv_idle_pct;
	bit hold_request;
	bit hold_done;

	logic [7:0] frame_bytes[$];

	settings_payload_parser_unit uut (
		.clk    (clk),
		.arst_n (arst_n),
		.payload(byte_ch),
		.report (result_ch)
	);

	settings_report_checker checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.payload        (byte_ch),
		.report         (result_ch),
		.failures       (failures),
		.outstanding    (outstanding),
		.reports_checked(reports_checked),
		.error_reports  (error_reports)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("Test completed with failures");
		$finish;
	end

	// Report receiver: random stalls, plus one long hold-off when asked for.
	initial begin : receiver
		int hold_left;
		hold_left = 0;
		hold_done = 1'b0;
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				result_ch.ready <= 1'b0;
				hold_left--;
			end else if (hold_request && !hold_done) begin
				hold_done = 1'b1;
				hold_left = 300;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	// Offer one payload item after a random gap and wait until it is taken.
	task automatic send_item(input logic [7:0] data, input logic [23:0] len,
			input logic last);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			byte_ch.valid <= 1'b0;
			@(posedge clk);
		end
		byte_ch.valid          <= 1'b1;
		byte_ch.data_byte      <= data;
		byte_ch.payload_length <= len;
		byte_ch.is_last        <= last;
		do @(posedge clk); while (!byte_ch.ready);
		items_sent++;
	endtask

	task automatic add_entry(input logic [15:0] id, input logic [31:0] val);
		frame_bytes.push_back(id[15:8]);
		frame_bytes.push_back(id[7:0]);
		frame_bytes.push_back(val[31:24]);
		frame_bytes.push_back(val[23:16]);
		frame_bytes.push_back(val[15:8]);
		frame_bytes.push_back(val[7:0]);
	endtask

	// Send the collected bytes as one frame; a frame with no bytes is a single item.
	task automatic send_frame(input logic [23:0] len);
		if (frame_bytes.size() == 0)
			frame_bytes.push_back(8'($urandom));
		foreach (frame_bytes[i])
			send_item(frame_bytes[i], len, i == frame_bytes.size() - 1);
		frame_bytes.delete();
	endtask

	// Values lean toward the limits of the checked settings.
	function automatic logic [31:0] pick_value(input logic [15:0] id);
		int r;
		r = $urandom_range(0, 99);
		case (id)
			ID_WINDOW: begin
				if (r < 15)
					return 32'h8000_0000 | $urandom;
				else if (r < 25)
					return 32'h7fff_ffff;
				return $urandom_range(0, 32'h7fff_ffff);
			end
			ID_FRAME_SIZE: begin
				if (r < 8)
					return $urandom_range(0, 16383);
				else if (r < 15)
					return $urandom_range(32'h0100_0000, 32'hffff_ffff);
				else if (r < 20)
					return 32'd16384;
				else if (r < 25)
					return 32'd16777215;
				return $urandom_range(16384, 16777215);
			end
			default: begin
				if (r < 10)
					return 32'd0;
				else if (r < 20)
					return 32'hffff_ffff;
				return $urandom;
			end
		endcase
	endfunction

	// Mostly well-formed frames with random entries; the rest is malformed noise.
	task automatic run_random_frames(input int target);
		int n;
		int r;
		int count;
		logic [15:0] id;
		logic [23:0] len;
		logic [23:0] base;
		while (items_sent < target) begin
			if ($urandom_range(0, 99) < 82) begin
				n = $urandom_range(0, 4);
				for (int i = 0; i < n; i++) begin
					r = $urandom_range(0, 99);
					if (r < 75)
						id = 16'($urandom_range(1, 6));
					else if (r < 85)
						id = 16'd0;
					else
						id = 16'($urandom);
					add_entry(id, pick_value(id));
				end
				// Occasionally a trailing partial entry that must be dropped.
				if ($urandom_range(0, 9) == 0)
					repeat ($urandom_range(1, 5)) frame_bytes.push_back(8'($urandom));
				if ($urandom_range(0, 4) == 0)
					len = 24'(6 * $urandom_range(0, 2796202));
				else
					len = 24'(6 * n);
				send_frame(len);
			end else begin
				count = $urandom_range(1, 12);
				if ($urandom_range(0, 1) == 0)
					base = 24'($urandom);
				else
					base = 24'(6 * $urandom_range(1, 2796202));
				for (int i = 0; i < count; i++) begin
					r = $urandom_range(0, 99);
					if (r < 20)
						len = 24'd0;
					else if (r < 35)
						len = 24'($urandom);
					else
						len = base;
					send_item(8'($urandom), len, i == count - 1);
				end
			end
		end
	endtask

	task automatic wait_for_reports();
		do @(posedge clk); while (outstanding != 0);
	endtask

	initial begin : stimulus
		arst_n                 <= 1'b0;
		byte_ch.valid          <= 1'b0;
		byte_ch.data_byte      <= 8'd0;
		byte_ch.payload_length <= 24'd0;
		byte_ch.is_last        <= 1'b0;
		items_sent    = 0;
		send_idle_pct = 16;
		recv_idle_pct = 63;
		hold_request  = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty frame reports the defaults.
		send_frame(24'd0);
		// Length not a multiple of six, at the top of the length range.
		frame_bytes.push_back(8'hff);
		frame_bytes.push_back(8'h00);
		send_frame(24'hff_ffff);
		// Frame size just below its legal range.
		add_entry(ID_FRAME_SIZE, 32'd16383);
		send_frame(24'd6);
		// Window one above its limit.
		add_entry(ID_WINDOW, 32'h8000_0000);
		send_frame(24'd6);
		// Push stored as received, then an unknown identifier at its maximum.
		add_entry(ID_PUSH, 32'hffff_ffff);
		add_entry(16'hffff, 32'd0);
		send_frame(24'hff_fffc);

		// Lightly throttled sender, heavily stalled receiver.
		run_random_frames(440);
		byte_ch.valid <= 1'b0;
		wait_for_reports();

		// Heavily throttled sender, lightly stalled receiver.
		send_idle_pct = 63;
		recv_idle_pct = 16;
		run_random_frames(850);

		// Full rate, with one long receiver hold-off.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_request  = 1'b1;
		run_random_frames(1250);
		byte_ch.valid <= 1'b0;

		wait_for_reports();
		repeat (8) @(posedge clk);
		$display("Sent %0d payload items; checked %0d settings reports, %0d of them flagged",
			items_sent, reports_checked, error_reports);
		$display("Throttling covered a slow sender, a slow receiver, full rate and a long stall.");
		if (failures == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
